// ===== rtl/pmct_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared widths, codes and the input transaction layout of the tracker.
// ----------------------------------------------------------------------------
package pmct_pkg;

  // Fixed field widths.
  localparam int unsigned SCREEN_BITS = 14;
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned DELTA_BITS  = 16;
  localparam int unsigned REQ_BITS    = 2;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam int unsigned IN_TDATA_BITS = 48;

  // Register reset values.
  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 14'd1024;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 14'd768;

  // Cursor position after reset.
  localparam int unsigned POS_X_RESET = 400;
  localparam int unsigned POS_Y_RESET = 300;

  // PS/2 header byte layout.
  localparam int unsigned SYNC_BIT_IDX  = 3;
  localparam int unsigned LEFT_BIT_IDX  = 0;
  localparam int unsigned RIGHT_BIT_IDX = 1;
  localparam logic [BYTE_BITS-1:0] OVERFLOW_MASK = 8'hC0;

  // Byte position within a packet.
  localparam logic [1:0] BYTE_POS_FIRST = 2'd0;
  localparam logic [1:0] BYTE_POS_LAST  = 2'd2;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_PS2_BYTE = 2'd0,
    REQ_DELTA    = 2'd1,
    REQ_BUTTONS  = 2'd2,
    REQ_UNUSED   = 2'd3
  } pmct_req_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_BYTE_STORED      = 3'd0,
    ST_BYTE_DROPPED     = 3'd1,
    ST_PACKET_APPLIED   = 3'd2,
    ST_PACKET_OVERFLOW  = 3'd3,
    ST_DELTA_APPLIED    = 3'd4,
    ST_BUTTONS_SET      = 3'd5
  } pmct_status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } pmct_cfg_e;

  // One input transaction after unpacking.
  typedef struct packed {
    pmct_req_e                     req_type;
    logic [BYTE_BITS-1:0]          data_byte;
    logic signed [DELTA_BITS-1:0]  delta_x;
    logic signed [DELTA_BITS-1:0]  delta_y;
    logic                          left_button;
    logic                          right_button;
  } pmct_item_t;

endpackage

// ===== rtl/pmct_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one accepted input transaction until the tracker consumes it.
// ----------------------------------------------------------------------------
module pmct_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pmct_pkg::pmct_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_take_i,
  output pmct_pkg::pmct_item_t out_item_o
);

  logic                 valid_q, valid_d;
  pmct_pkg::pmct_item_t item_q;
  logic                 accept;

  // The register is free when empty or when its item leaves this cycle.
  assign in_ready_o = !valid_q || out_take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload carries no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== rtl/pmct_axis_clamp.sv =====
// ----------------------------------------------------------------------------
// Axis clamp
// Adds a signed delta to one cursor coordinate and saturates to the screen.
// ----------------------------------------------------------------------------
module pmct_axis_clamp #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic [COORD_BITS-1:0]                   pos_i,
  input  logic signed [pmct_pkg::DELTA_BITS-1:0]  delta_i,
  input  logic [pmct_pkg::SCREEN_BITS-1:0]        size_i,
  output logic [COORD_BITS-1:0]                   pos_o
);

  localparam int unsigned WideBits =
      (COORD_BITS > pmct_pkg::DELTA_BITS) ? COORD_BITS : pmct_pkg::DELTA_BITS;
  localparam int unsigned SumBits  =
      ((WideBits > pmct_pkg::SCREEN_BITS) ? WideBits : pmct_pkg::SCREEN_BITS) + 2;

  logic signed [SumBits-1:0] sum;
  logic signed [SumBits-1:0] lim;
  logic signed [SumBits-1:0] res;

  // A zero screen size behaves as a size of one.
  always_comb begin
    sum = $signed(SumBits'(pos_i)) + SumBits'(delta_i);
    lim = (size_i == '0) ? $signed(SumBits'(1)) : $signed(SumBits'(size_i));
    if (sum[SumBits-1]) begin
      res = '0;
    end else if (sum >= lim) begin
      res = lim - $signed(SumBits'(1));
    end else begin
      res = sum;
    end
  end

  assign pos_o = res[COORD_BITS-1:0];

endmodule

// ===== rtl/pmct_tracker.sv =====
// ----------------------------------------------------------------------------
// Tracker core
// Packet assembly, cursor and button state, and the result register.
// ----------------------------------------------------------------------------
module pmct_tracker #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  input  pmct_pkg::pmct_item_t                item_i,
  output logic                                take_o,
  input  logic [pmct_pkg::SCREEN_BITS-1:0]    screen_width_i,
  input  logic [pmct_pkg::SCREEN_BITS-1:0]    screen_height_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output pmct_pkg::pmct_status_e              status_o,
  output logic [COORD_BITS-1:0]               cursor_x_o,
  output logic [COORD_BITS-1:0]               cursor_y_o,
  output logic                                left_o,
  output logic                                right_o
);

  logic [1:0]                             byte_pos_q, byte_pos_d;
  logic [pmct_pkg::BYTE_BITS-1:0]         pkt0_q, pkt0_d;
  logic [pmct_pkg::BYTE_BITS-1:0]         pkt1_q, pkt1_d;
  logic [COORD_BITS-1:0]                  pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0]                  pos_y_q, pos_y_d;
  logic                                   left_q, left_d;
  logic                                   right_q, right_d;
  logic                                   res_valid_q, res_valid_d;
  pmct_pkg::pmct_status_e                 status_q, status_d;
  logic                                   move_en;
  logic signed [pmct_pkg::DELTA_BITS-1:0] dx;
  logic signed [pmct_pkg::DELTA_BITS-1:0] dy;
  logic [COORD_BITS-1:0]                  moved_x;
  logic [COORD_BITS-1:0]                  moved_y;
  logic [pmct_pkg::BYTE_BITS-1:0]         data_b;

  // An item is consumed when the result register is free or being drained.
  assign take_o = item_valid_i && (!res_valid_q || res_ready_i);
  assign data_b = item_i.data_byte;

  // Decode the item and work out the next state.
  always_comb begin
    byte_pos_d = byte_pos_q;
    pkt0_d     = pkt0_q;
    pkt1_d     = pkt1_q;
    left_d     = left_q;
    right_d    = right_q;
    move_en    = 1'b0;
    dx         = item_i.delta_x;
    dy         = item_i.delta_y;
    status_d   = pmct_pkg::ST_BYTE_DROPPED;
    case (item_i.req_type)
      pmct_pkg::REQ_PS2_BYTE: begin
        if (byte_pos_q == pmct_pkg::BYTE_POS_FIRST &&
            !data_b[pmct_pkg::SYNC_BIT_IDX]) begin
          // Not a header byte: drop it to regain framing.
          status_d = pmct_pkg::ST_BYTE_DROPPED;
        end else if (byte_pos_q != pmct_pkg::BYTE_POS_LAST) begin
          if (byte_pos_q == pmct_pkg::BYTE_POS_FIRST) begin
            pkt0_d = data_b;
          end else begin
            pkt1_d = data_b;
          end
          byte_pos_d = byte_pos_q + 2'd1;
          status_d   = pmct_pkg::ST_BYTE_STORED;
        end else begin
          // Third byte completes the packet; buttons are taken regardless.
          byte_pos_d = pmct_pkg::BYTE_POS_FIRST;
          left_d     = pkt0_q[pmct_pkg::LEFT_BIT_IDX];
          right_d    = pkt0_q[pmct_pkg::RIGHT_BIT_IDX];
          if ((pkt0_q & pmct_pkg::OVERFLOW_MASK) != '0) begin
            status_d = pmct_pkg::ST_PACKET_OVERFLOW;
          end else begin
            move_en  = 1'b1;
            dx       = {{(pmct_pkg::DELTA_BITS-pmct_pkg::BYTE_BITS){pkt1_q[7]}}, pkt1_q};
            dy       = -{{(pmct_pkg::DELTA_BITS-pmct_pkg::BYTE_BITS){data_b[7]}}, data_b};
            status_d = pmct_pkg::ST_PACKET_APPLIED;
          end
        end
      end
      pmct_pkg::REQ_DELTA: begin
        move_en  = 1'b1;
        status_d = pmct_pkg::ST_DELTA_APPLIED;
      end
      pmct_pkg::REQ_BUTTONS: begin
        left_d   = item_i.left_button;
        right_d  = item_i.right_button;
        status_d = pmct_pkg::ST_BUTTONS_SET;
      end
      default: begin
        status_d = pmct_pkg::ST_BYTE_DROPPED;
      end
    endcase
  end

  pmct_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .pos_i   (pos_x_q),
    .delta_i (dx),
    .size_i  (screen_width_i),
    .pos_o   (moved_x)
  );

  pmct_axis_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .pos_i   (pos_y_q),
    .delta_i (dy),
    .size_i  (screen_height_i),
    .pos_o   (moved_y)
  );

  assign pos_x_d = move_en ? moved_x : pos_x_q;
  assign pos_y_d = move_en ? moved_y : pos_y_q;

  // Result valid flag follows the output handshake.
  always_comb begin
    res_valid_d = res_valid_q;
    if (take_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  // Control and architectural state; all but the result valid flag update only when an item is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      byte_pos_q  <= pmct_pkg::BYTE_POS_FIRST;
      pos_x_q     <= COORD_BITS'(pmct_pkg::POS_X_RESET);
      pos_y_q     <= COORD_BITS'(pmct_pkg::POS_Y_RESET);
      left_q      <= 1'b0;
      right_q     <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take_o) begin
        byte_pos_q <= byte_pos_d;
        pos_x_q    <= pos_x_d;
        pos_y_q    <= pos_y_d;
        left_q     <= left_d;
        right_q    <= right_d;
      end
    end
  end

  // Packet bytes and status payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      pkt0_q   <= pkt0_d;
      pkt1_q   <= pkt1_d;
      status_q <= status_d;
    end
  end

  // The state only moves together with a new result, so it doubles as the
  // result payload and stays stable while the result waits.
  assign res_valid_o = res_valid_q;
  assign status_o    = status_q;
  assign cursor_x_o  = pos_x_q;
  assign cursor_y_o  = pos_y_q;
  assign left_o      = left_q;
  assign right_o     = right_q;

endmodule

// ===== rtl/ps2_mouse_cursor_tracker_core.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Assembles three-byte PS/2 mouse packets, applies direct deltas and button
// writes, and reports the saturated cursor position and buttons per item.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock while the sink accepts
// results, and returns exactly one result transaction for each, in order. A
// result reaches the master side by way of the input register, which holds the
// accepted item, and the result register, which captures it once free. The
// sustained rate is one item per cycle, set by the update of the cursor and
// button state, which each item reads and writes.
// The output holds while the sink stalls, and the input register absorbs one
// further item. Screen size registers should only be written while no item is
// in flight; a write does not move the cursor until the next movement.
module ps2_mouse_cursor_tracker_core #(
  parameter int unsigned COORD_BITS = 14,
  localparam int unsigned OutBits = ((2 * COORD_BITS + 2 + 7) / 8) * 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input stream.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // data_byte[7:0], delta_x[23:8], delta_y[39:24], left_button[40],
  // right_button[41], zero fill above.
  input  logic [pmct_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
  // req_type[1:0].
  input  logic [pmct_pkg::REQ_BITS-1:0]         s_axis_tuser,
  // Result stream.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // cursor_x, cursor_y, left_pressed, right_pressed from bit 0 up, zero fill.
  output logic [OutBits-1:0]                    m_axis_tdata,
  // event_status[2:0].
  output logic [pmct_pkg::STATUS_BITS-1:0]      m_axis_tuser,
  // Register write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pmct_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [pmct_pkg::SCREEN_BITS-1:0]      cfg_data_i
);

  pmct_pkg::pmct_item_t                 in_item;
  pmct_pkg::pmct_item_t                 reg_item;
  logic                                 reg_valid;
  logic                                 take;
  logic [pmct_pkg::SCREEN_BITS-1:0]     width_q, width_d;
  logic [pmct_pkg::SCREEN_BITS-1:0]     height_q, height_d;
  pmct_pkg::pmct_status_e               status;
  logic [COORD_BITS-1:0]                cursor_x;
  logic [COORD_BITS-1:0]                cursor_y;
  logic                                 left_pressed;
  logic                                 right_pressed;

  // Unpack the input transaction.
  always_comb begin
    in_item.req_type     = pmct_pkg::pmct_req_e'(s_axis_tuser);
    in_item.data_byte    = s_axis_tdata[7:0];
    in_item.delta_x      = s_axis_tdata[23:8];
    in_item.delta_y      = s_axis_tdata[39:24];
    in_item.left_button  = s_axis_tdata[40];
    in_item.right_button = s_axis_tdata[41];
  end

  // Screen size registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (pmct_pkg::pmct_cfg_e'(cfg_index_i))
        pmct_pkg::CFG_SCREEN_WIDTH:  width_d = cfg_data_i;
        pmct_pkg::CFG_SCREEN_HEIGHT: height_d = cfg_data_i;
        default: begin
          width_d = width_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pmct_pkg::SCREEN_WIDTH_RESET;
      height_q <= pmct_pkg::SCREEN_HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  pmct_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (reg_valid),
    .out_take_i  (take),
    .out_item_o  (reg_item)
  );

  pmct_tracker #(.COORD_BITS(COORD_BITS)) u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (reg_valid),
    .item_i          (reg_item),
    .take_o          (take),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .status_o        (status),
    .cursor_x_o      (cursor_x),
    .cursor_y_o      (cursor_y),
    .left_o          (left_pressed),
    .right_o         (right_pressed)
  );

  // Pack the result transaction.
  assign m_axis_tuser = status;
  assign m_axis_tdata = OutBits'({right_pressed, left_pressed, cursor_y, cursor_x});

endmodule

// ===== rtl/pmct_checker.sv =====
// ----------------------------------------------------------------------------
// Tracker port checker
// Watches the ports of the cursor tracker and flags illegal behavior.
// ----------------------------------------------------------------------------
module pmct_checker #(
  parameter int unsigned COORD_BITS = 14,
  localparam int unsigned OutBits = ((2 * COORD_BITS + 2 + 7) / 8) * 8
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [OutBits-1:0]                 m_axis_tdata,
  input logic [pmct_pkg::STATUS_BITS-1:0]   m_axis_tuser
);

  localparam int unsigned CurBits = 2 * COORD_BITS;

  // A stalled result transaction keeps its contents.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only defined status codes are reported.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= pmct_pkg::ST_BUTTONS_SET)
    else $error("undefined status code");

  // An accepted item reaches the output once the result slot is free.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready ##1 (!m_axis_tvalid || m_axis_tready))
      |=> m_axis_tvalid)
    else $error("accepted item did not produce a result");

  // Items that do not move the cursor report the previous position.
  a_cursor_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready ##1
      (m_axis_tvalid && (m_axis_tuser == pmct_pkg::ST_BYTE_STORED ||
                         m_axis_tuser == pmct_pkg::ST_BYTE_DROPPED ||
                         m_axis_tuser == pmct_pkg::ST_PACKET_OVERFLOW ||
                         m_axis_tuser == pmct_pkg::ST_BUTTONS_SET)))
      |-> m_axis_tdata[CurBits-1:0] == $past(m_axis_tdata[CurBits-1:0]))
    else $error("cursor moved on a non-movement item");

endmodule

bind ps2_mouse_cursor_tracker_core pmct_checker #(.COORD_BITS(COORD_BITS)) u_pmct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
